// File: src/s2d_pkg.sv
// Shared types, constants and the power-of-ten table for the decimal text converter.
`timescale 1ns / 1ps

package s2d_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DEC_W      = 4;
  localparam int POW_W      = 30;   // 10^9 fits in 30 bits
  localparam int WEIGHT_W   = 33;   // 8 * 10^9 fits in 33 bits
  localparam int STEP_W     = 2;    // four trial subtractions per digit

  localparam logic [DEC_W-1:0]  LAST_DEC   = 4'd9;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_CALC,
    ST_PUT
  } state_t;

  // one character handed from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] character;
    logic              last;
  } emit_t;

  // 10^(9-d): decade 0 is the billions place
  function automatic logic [POW_W-1:0] pow10(input logic [DEC_W-1:0] d);
    logic [POW_W-1:0] p;
    unique case (d)
      4'd0:    p = 30'd1000000000;
      4'd1:    p = 30'd100000000;
      4'd2:    p = 30'd10000000;
      4'd3:    p = 30'd1000000;
      4'd4:    p = 30'd100000;
      4'd5:    p = 30'd10000;
      4'd6:    p = 30'd1000;
      4'd7:    p = 30'd100;
      4'd8:    p = 30'd10;
      4'd9:    p = 30'd1;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

// File: src/s2d_csub.sv
// Shared compare-and-subtract unit: trial subtraction of 8, 4, 2 or 1 times a power of ten.
`timescale 1ns / 1ps

module s2d_csub
  import s2d_pkg::*;
(
  input  logic [VALUE_W-1:0] mag,
  input  logic [DEC_W-1:0]   dec,
  input  logic [STEP_W-1:0]  step,
  output logic               ge,
  output logic [VALUE_W-1:0] diff
);

  logic [WEIGHT_W-1:0] weight;
  logic [STEP_W-1:0]   shamt;

  // step 0 tries 8x, step 3 tries 1x
  assign shamt  = ~step;
  assign weight = WEIGHT_W'(pow10(dec)) << shamt;
  assign ge     = {1'b0, mag} >= weight;
  assign diff   = mag - weight[VALUE_W-1:0];

endmodule

// File: src/s2d_ctrl.sv
// Sequencer: sign, per-digit trial subtraction steps, leading zero suppression.
`timescale 1ns / 1ps

module s2d_ctrl
  import s2d_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      in_ready,
  input  logic                      room,
  output emit_t                     emit,
  output logic [VALUE_W-1:0]        mag_r,
  output logic [DEC_W-1:0]          dec_r,
  output logic [STEP_W-1:0]         step_r,
  input  logic                      ge,
  input  logic [VALUE_W-1:0]        diff
);

  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] mag_nxt;
  logic [DEC_W-1:0]   dec_nxt;
  logic [STEP_W-1:0]  step_nxt;
  logic [3:0]         digit_r, digit_nxt;
  logic               started_r, started_nxt;
  logic               show;
  logic [VALUE_W-1:0] raw;

  assign raw  = in_value;
  // a digit shows once the number has started, or it is the units place
  assign show = started_r || (digit_r != 4'd0) || (dec_r == LAST_DEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = raw[VALUE_W-1] ? ST_SIGN : ST_CALC;
      end
      ST_SIGN: begin
        if (room) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (step_r == 2'd3) state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (!show) state_nxt = ST_CALC;
        else if (room) state_nxt = (dec_r == LAST_DEC) ? ST_IDLE : ST_CALC;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    emit.valid     = (state_r == ST_SIGN) || ((state_r == ST_PUT) && show);
    emit.character = (state_r == ST_SIGN) ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(digit_r));
    emit.last      = (state_r == ST_PUT) && (dec_r == LAST_DEC);
  end

  always_comb begin
    mag_nxt     = mag_r;
    dec_nxt     = dec_r;
    step_nxt    = step_r;
    digit_nxt   = digit_r;
    started_nxt = started_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // 32-bit negate; the most negative value maps to 2^31
          mag_nxt     = raw[VALUE_W-1] ? (~raw + 32'd1) : raw;
          dec_nxt     = '0;
          step_nxt    = '0;
          digit_nxt   = '0;
          started_nxt = 1'b0;
        end
      end
      ST_CALC: begin
        if (ge) mag_nxt = diff;
        digit_nxt[~step_r] = ge;
        step_nxt = step_r + 2'd1;
      end
      ST_PUT: begin
        if ((!show || room) && (dec_r != LAST_DEC)) begin
          dec_nxt     = dec_r + 4'd1;
          digit_nxt   = '0;
          started_nxt = started_r || show;
        end
      end
      ST_SIGN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    dec_r     <= dec_nxt;
    step_r    <= step_nxt;
    digit_r   <= digit_nxt;
    started_r <= started_nxt;
  end

endmodule

// File: src/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII text, one character per output word.
`timescale 1ns / 1ps

// Accepts one signed 32-bit value and sends its decimal text, one ASCII
// character per output word: a leading '-' for negative values, then the
// digits without leading zeros (zero gives a single '0'); out_last marks the
// final character. No divider: each digit is found by four trial
// subtractions (8x, 4x, 2x, 1x the power of ten) on one shared
// compare-subtract unit, one per cycle. After the value is accepted, the sign is
// handed off for a negative value, then each of the ten decades takes four
// subtraction steps and one digit hand-off step. in_ready is low from
// acceptance until the last character has entered the output register;
// back-pressure on out_ready stalls the sign and digit hand-offs.

module signed_int_to_decimal_ascii
  import s2d_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CHAR_W-1:0]         out_character,
  output logic                      out_last
);

  logic               room;
  emit_t              emit;
  logic [VALUE_W-1:0] mag;
  logic [DEC_W-1:0]   dec;
  logic [STEP_W-1:0]  step;
  logic               ge;
  logic [VALUE_W-1:0] diff;

  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_character_r;
  logic               out_last_r;

  s2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_value (in_value),
    .in_ready (in_ready),
    .room     (room),
    .emit     (emit),
    .mag_r    (mag),
    .dec_r    (dec),
    .step_r   (step),
    .ge       (ge),
    .diff     (diff)
  );

  s2d_csub u_csub (
    .mag  (mag),
    .dec  (dec),
    .step (step),
    .ge   (ge),
    .diff (diff)
  );

  // output register takes a new word when empty or being drained
  assign room = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (room) begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && emit.valid) begin
      out_character_r <= emit.character;
      out_last_r      <= emit.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule

// File: src/s2d_checker.sv
// Port-level checks for the decimal text converter, bound to the top level.
`timescale 1ns / 1ps

module s2d_checker
  import s2d_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [CHAR_W-1:0]         out_character,
  input logic                      out_last
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("output word changed while stalled");

  // converter is busy right after taking a value
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again without conversion");

  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS) ||
                  ((out_character >= CHAR_ZERO) && (out_character <= CHAR_ZERO + 8'd9)))
    else $error("character outside sign and digits");

  // a minus sign is always followed by at least one digit
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as last");

endmodule

bind signed_int_to_decimal_ascii s2d_checker u_s2d_checker (.*);
